/* rtl/sqe_pkg.sv */
// Shared widths, opcodes, coil table and controller/datapath handshake types.
package sqe_pkg;

  localparam int RX_W        = 8;
  localparam int WORD_W      = 32;
  localparam int MSEL_W      = 3;
  localparam int COIL_W      = 4;
  localparam int DIR_W       = 2;
  localparam int PHASE_W     = 3;
  localparam int STEP_INC_W  = 2;
  localparam int LEFT_W      = 2;
  localparam int SLOT_W      = 2;
  localparam int MAX_WRITES  = 6;

  // request kinds on the input channel
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // command opcodes (first byte)
  localparam logic [RX_W-1:0] OP_KILL     = 8'd0;
  localparam logic [RX_W-1:0] OP_RESUME   = 8'd1;
  localparam logic [RX_W-1:0] OP_CLEAR    = 8'd2;
  localparam logic [RX_W-1:0] OP_GOTO     = 8'd3;
  localparam logic [RX_W-1:0] OP_FORWARD  = 8'd4;
  localparam logic [RX_W-1:0] OP_REVERSE  = 8'd5;
  localparam logic [RX_W-1:0] OP_TOGETHER = 8'd6;
  localparam logic [RX_W-1:0] OP_OFF      = 8'd7;
  localparam logic [RX_W-1:0] OP_FREEZE   = 8'd8;

  // motor byte of an off command that addresses every motor
  localparam logic [RX_W-1:0] ALL_MOTORS_CODE = 8'd6;

  // step direction codes
  localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_STOP = 2'sb00;

  // initial values
  localparam logic [PHASE_W-1:0]    PHASE_RESET    = 3'd1;
  localparam logic [STEP_INC_W-1:0] STEP_INC_RESET = 2'd1;
  localparam logic [SLOT_W-1:0]     SLOT_FIRST     = 2'd1;

  // half-step coil pattern for a phase, bit0 is coil A
  function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] c;
    unique case (ph)
      3'd0: c = 4'h1;
      3'd1: c = 4'h5;
      3'd2: c = 4'h4;
      3'd3: c = 4'h6;
      3'd4: c = 4'h2;
      3'd5: c = 4'hA;
      3'd6: c = 4'h8;
      3'd7: c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  // what the head entry asks for once it has been read
  typedef enum logic [1:0] {
    EX_STEP,
    EX_OFF_ONE,
    EX_OFF_ALL,
    EX_DISCARD
  } sqe_exec_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic read_head;
    logic exec_step;
    logic exec_off_one;
    logic exec_discard;
    logic stop_clr;
    logic stop_load;
  } sqe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      kill_byte;
    logic      tick_go;
    sqe_exec_t exec_class;
    logic      out_free;
    logic      stop_last;
  } sqe_stat_t;

endpackage

/* rtl/sqe_if.sv */
// Valid/ready stream interfaces for the request and result channels.
interface sqe_in_if;
  import sqe_pkg::*;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [RX_W-1:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface sqe_out_if;
  import sqe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MSEL_W-1:0]       motor_select;
  logic [COIL_W-1:0]       coil_pattern;
  logic signed [DIR_W-1:0] step_direction;
  logic                    last_write;
  logic                    running;
  logic                    overflow;

  modport source (output valid, motor_select, coil_pattern, step_direction, last_write,
                  running, overflow, input ready);
  modport sink   (input valid, motor_select, coil_pattern, step_direction, last_write,
                  running, overflow, output ready);
endinterface

/* rtl/sqe_ctrl.sv */
// Sequencing state machine: accepts requests and steers the datapath.
module sqe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  sqe_pkg::sqe_stat_t stat,
  output sqe_pkg::sqe_cmd_t  cmd
);
  import sqe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STOP
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_BYTE) begin
            cmd.take_byte = 1'b1;
            if (stat.kill_byte) begin
              cmd.stop_clr = 1'b1;
              state_nxt    = S_STOP;
            end
          end else if (stat.tick_go) begin
            cmd.read_head = 1'b1;
            state_nxt     = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        unique case (stat.exec_class)
          EX_STEP: begin
            if (stat.out_free) begin
              cmd.exec_step = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          EX_OFF_ONE: begin
            if (stat.out_free) begin
              cmd.exec_off_one = 1'b1;
              state_nxt        = S_IDLE;
            end
          end
          EX_OFF_ALL: begin
            cmd.exec_discard = 1'b1;
            cmd.stop_clr     = 1'b1;
            state_nxt        = S_STOP;
          end
          EX_DISCARD: begin
            cmd.exec_discard = 1'b1;
            state_nxt        = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_STOP: begin
        if (stat.out_free) begin
          cmd.stop_load = 1'b1;
          if (stat.stop_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/sqe_datapath.sv */
// Command assembly, queue memory, motor phases and the result register.
module sqe_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MOTOR_COUNT = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sqe_pkg::STEP_INC_W-1:0]  cfg_data,
  input  logic [sqe_pkg::RX_W-1:0]        rx_byte,
  input  sqe_pkg::sqe_cmd_t               cmd,
  output sqe_pkg::sqe_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sqe_pkg::MSEL_W-1:0]      motor_select,
  output logic [sqe_pkg::COIL_W-1:0]      coil_pattern,
  output logic signed [sqe_pkg::DIR_W-1:0] step_direction,
  output logic                            last_write,
  output logic                            running,
  output logic                            overflow
);
  import sqe_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MW     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int STOP_N = (MOTOR_COUNT < MAX_WRITES) ? MOTOR_COUNT : MAX_WRITES;

  // queue
  logic [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [FILL_W-1:0] fill_r;
  logic [WORD_W-1:0] hd_word_r;

  // command assembly and flags
  logic [LEFT_W-1:0]     left_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [WORD_W-1:0]     asm_r;
  logic                  enable_r;
  logic                  drop_r;
  logic [STEP_INC_W-1:0] step_inc_r;
  logic [PHASE_W-1:0]    phase_r [MOTOR_COUNT];
  logic [MSEL_W-1:0]     stop_cnt_r;

  // result register
  logic                    out_valid_r;
  logic [MSEL_W-1:0]       msel_r;
  logic [COIL_W-1:0]       coil_r;
  logic signed [DIR_W-1:0] dir_r;
  logic                    last_r;
  logic                    run_r;
  logic                    ovf_r;

  logic [WORD_W-1:0] asm_new;
  logic              push, do_push, pop;
  logic [RX_W-1:0]   hd_op, hd_motor, cnt_new;
  logic              motor_ok;
  logic [MW-1:0]     midx;
  logic [PHASE_W-1:0] phase_new;
  logic              load;
  logic [PTR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  sqe_exec_t         exec_cls;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // byte goes into its slot; command is complete on the last one
  always_comb begin
    asm_new = asm_r;
    asm_new[slot_r*RX_W +: RX_W] = rx_byte;
  end
  assign push    = cmd.take_byte && (left_r != '0) && (left_r == LEFT_W'(1));
  assign do_push = push && (fill_r < FILL_W'(QUEUE_DEPTH));

  // head entry decode
  assign hd_op     = hd_word_r[RX_W-1:0];
  assign hd_motor  = hd_word_r[2*RX_W-1:RX_W];
  assign cnt_new   = hd_word_r[3*RX_W-1:2*RX_W] - 1'b1;
  assign motor_ok  = (hd_motor < RX_W'(MOTOR_COUNT));
  assign midx      = hd_motor[MW-1:0];
  assign phase_new = (hd_op == OP_FORWARD)
                   ? phase_r[midx] + PHASE_W'(step_inc_r)
                   : phase_r[midx] - PHASE_W'(step_inc_r);

  always_comb begin
    if ((hd_op == OP_FORWARD || hd_op == OP_REVERSE) && motor_ok) begin
      exec_cls = EX_STEP;
    end else if (hd_op == OP_OFF && motor_ok) begin
      exec_cls = EX_OFF_ONE;
    end else if (hd_op == OP_OFF && hd_motor == ALL_MOTORS_CODE) begin
      exec_cls = EX_OFF_ALL;
    end else begin
      exec_cls = EX_DISCARD;
    end
  end

  assign stat.exec_class = exec_cls;
  assign stat.kill_byte  = (left_r == '0) && (rx_byte == OP_KILL);
  assign stat.tick_go    = enable_r && (fill_r != '0);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.stop_last  = (stop_cnt_r == MSEL_W'(STOP_N - 1));

  assign pop  = cmd.exec_discard || cmd.exec_off_one || (cmd.exec_step && cnt_new == '0);
  assign load = cmd.exec_step || cmd.exec_off_one || cmd.stop_load;

  // queue memory: push at tail, count write-back at head
  assign mem_waddr = cmd.exec_step ? head_r : tail_r;
  assign mem_wdata = cmd.exec_step
                   ? {hd_word_r[WORD_W-1:3*RX_W], cnt_new, hd_word_r[2*RX_W-1:0]}
                   : asm_new;

  always_ff @(posedge clk) begin
    if (do_push || cmd.exec_step) mem[mem_waddr] <= mem_wdata;
    if (cmd.read_head) hd_word_r <= mem[head_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      left_r      <= '0;
      slot_r      <= SLOT_FIRST;
      asm_r       <= '0;
      enable_r    <= 1'b1;
      drop_r      <= 1'b0;
      step_inc_r  <= STEP_INC_RESET;
      stop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < MOTOR_COUNT; m++) phase_r[m] <= PHASE_RESET;
    end else begin
      if (cfg_we) step_inc_r <= cfg_data;

      // serial byte handling
      if (cmd.take_byte) begin
        if (left_r != '0) begin
          asm_r  <= asm_new;
          slot_r <= slot_r + 1'b1;
          left_r <= left_r - 1'b1;
          if (push && !do_push) drop_r <= 1'b1;
        end else begin
          slot_r <= SLOT_FIRST;
          unique case (rx_byte)
            OP_KILL:   enable_r <= 1'b0;
            OP_RESUME: enable_r <= 1'b1;
            OP_CLEAR: begin
              head_r <= '0;
              tail_r <= '0;
              fill_r <= '0;
            end
            OP_GOTO: begin
              left_r <= LEFT_W'(3);
              asm_r  <= WORD_W'(rx_byte);
            end
            OP_FORWARD, OP_REVERSE: begin
              left_r <= LEFT_W'(2);
              asm_r  <= WORD_W'(rx_byte);
            end
            OP_TOGETHER, OP_OFF: begin
              left_r <= LEFT_W'(1);
              asm_r  <= WORD_W'(rx_byte);
            end
            default: ;
          endcase
        end
      end

      // queue pointers
      if (do_push) begin
        tail_r <= ptr_inc(tail_r);
        fill_r <= fill_r + 1'b1;
      end
      if (pop) begin
        head_r <= ptr_inc(head_r);
        fill_r <= fill_r - 1'b1;
      end

      // head execution
      if (cmd.exec_step) phase_r[midx] <= phase_new;
      if (cmd.exec_discard && hd_op == OP_FREEZE) enable_r <= 1'b0;

      // stop-all sweep counter
      if (cmd.stop_clr) begin
        stop_cnt_r <= '0;
      end else if (cmd.stop_load) begin
        stop_cnt_r <= stop_cnt_r + 1'b1;
      end

      // result handshake and pending overflow
      if (load) begin
        out_valid_r <= 1'b1;
        drop_r      <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= enable_r;
      ovf_r <= drop_r;
      if (cmd.exec_step) begin
        msel_r <= hd_motor[MSEL_W-1:0];
        coil_r <= coil_of(phase_new);
        dir_r  <= (hd_op == OP_FORWARD) ? DIR_FWD : DIR_REV;
        last_r <= 1'b1;
      end else if (cmd.exec_off_one) begin
        msel_r <= hd_motor[MSEL_W-1:0];
        coil_r <= '0;
        dir_r  <= DIR_STOP;
        last_r <= 1'b1;
      end else begin
        msel_r <= stop_cnt_r;
        coil_r <= '0;
        dir_r  <= DIR_STOP;
        last_r <= stat.stop_last;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign motor_select   = msel_r;
  assign coil_pattern   = coil_r;
  assign step_direction = dir_r;
  assign last_write     = last_r;
  assign running        = run_r;
  assign overflow       = ovf_r;

endmodule

/* rtl/stepper_command_queue_executor.sv */
// Stepper command queue executor: serial command FIFO driving unipolar motor coils.
// Serial byte: no result unless a kill byte; a byte may follow every cycle while idle.
// Tick request: if enabled and the queue holds an entry, the head entry is read into a
//   register at accept, executed once the output is free, and its result is registered.
// Kill byte, off-all entry: N stop results, one per cycle while output is free (N <= 6).
// Reset: synchronous, active low; queue empty, phases 1, execution enabled, no clearing pass.
module stepper_command_queue_executor #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MOTOR_COUNT = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sqe_in_if.sink                         in_if,
  sqe_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [sqe_pkg::STEP_INC_W-1:0] cfg_data
);
  import sqe_pkg::*;

  sqe_cmd_t  cmd;
  sqe_stat_t stat;

  sqe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_kind  (in_if.kind),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sqe_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .rx_byte        (in_if.rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .motor_select   (out_if.motor_select),
    .coil_pattern   (out_if.coil_pattern),
    .step_direction (out_if.step_direction),
    .last_write     (out_if.last_write),
    .running        (out_if.running),
    .overflow       (out_if.overflow)
  );

endmodule
